@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/psfbt_pkg.sv @@
package psfbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam logic [1:0] CMD_CHECK        = 2'd0;
    localparam logic [1:0] CMD_CHECK_TICKET = 2'd1;
    localparam logic [1:0] CMD_ADD          = 2'd2;
    localparam logic [1:0] CMD_SWEEP        = 2'd3;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_MAX    = 2'd1;
    localparam logic [1:0] REG_BAN    = 2'd2;
    localparam logic [1:0] REG_FORGET = 2'd3;

    localparam logic [15:0] WINDOW_RST = 16'd60;
    localparam logic [15:0] MAX_RST    = 16'd300;
    localparam logic [15:0] BAN_RST    = 16'd600;
    localparam logic [15:0] FORGET_RST = 16'd300;

    typedef struct packed {
        logic               valid;
        logic [47:0]        addr;
        logic [31:0]        last_seen;
        logic [31:0]        window_start;
        logic [31:0]        ban_until;
        logic signed [31:0] tickets;
        logic [15:0]        bans;
    } t_rec;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] max_tickets;
        logic [15:0] ban;
        logic [15:0] forget;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_TICKET  = 2'd0,
        OP_RECHECK = 2'd1,
        OP_SWEEP   = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic [8:0]         removed;
        logic signed [31:0] tickets;
        logic [15:0]        bans;
        logic               full;
        logic               banned;
        logic               created;
        logic               found;
        logic               allowed;
    } t_result;

endpackage

@@ hdl/psfbt_ram.sv @@
module psfbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/psfbt_alu.sv @@
module psfbt_alu (
    input  psfbt_pkg::t_rec    i_rec,
    input  psfbt_pkg::t_alu_op i_op,
    input  logic signed [10:0] i_delta,
    input  logic [31:0]        i_now,
    input  psfbt_pkg::t_cfg    i_cfg,
    output psfbt_pkg::t_rec    o_rec,
    output logic               o_banned,
    output logic               o_removed
);

    logic signed [32:0] tsum;
    logic signed [31:0] tsat;
    logic               hit_max;
    logic [31:0]        ban_base;
    logic [32:0]        ban_sum;
    logic [32:0]        win_sum;
    logic [32:0]        fgt_sum;
    logic               win_over;
    logic               ban_over;
    psfbt_pkg::t_rec    rck;

    always_comb begin
        tsum = $signed({i_rec.tickets[31], i_rec.tickets})
             + $signed({{22{i_delta[10]}}, i_delta});
        if (tsum[32] != tsum[31]) begin
            tsat = tsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            tsat = tsum[31:0];
        end
        hit_max  = $signed({tsat[31], tsat}) >= $signed({17'b0, i_cfg.max_tickets});
        ban_base = (i_rec.ban_until > i_now) ? i_rec.ban_until : i_now;
        ban_sum  = {1'b0, ban_base} + {17'b0, i_cfg.ban};

        win_sum  = {1'b0, i_rec.window_start} + {17'b0, i_cfg.window};
        fgt_sum  = {1'b0, i_rec.last_seen} + {17'b0, i_cfg.forget};
        win_over = win_sum <= {1'b0, i_now};
        ban_over = (i_rec.ban_until != 32'd0) && (i_rec.ban_until <= i_now);

        rck = i_rec;
        if (win_over) begin
            rck.window_start = i_now;
            rck.tickets      = '0;
        end
        if (ban_over) begin
            rck.ban_until = '0;
            rck.last_seen = i_now;
        end

        o_rec     = i_rec;
        o_banned  = 1'b0;
        o_removed = 1'b0;
        case (i_op)
            psfbt_pkg::OP_TICKET: begin
                o_rec.tickets   = tsat;
                o_rec.last_seen = i_now;
                if (hit_max) begin
                    o_banned        = 1'b1;
                    o_rec.ban_until = ban_sum[32] ? 32'hffff_ffff : ban_sum[31:0];
                    o_rec.tickets   = '0;
                    if (i_rec.bans != 16'hffff) begin
                        o_rec.bans = i_rec.bans + 16'd1;
                    end
                end
            end
            psfbt_pkg::OP_RECHECK: begin
                o_rec = rck;
            end
            psfbt_pkg::OP_SWEEP: begin
                if (i_rec.valid) begin
                    if (i_rec.ban_until == 32'd0 && fgt_sum <= {1'b0, i_now}) begin
                        o_rec.valid = 1'b0;
                        o_removed   = 1'b1;
                    end else begin
                        o_rec = rck;
                    end
                end
            end
            default: begin
                o_rec = i_rec;
            end
        endcase
    end

endmodule

@@ hdl/per_source_flood_ban_table_core.sv @@
// a check reads and compares slots up to the match, then the ticket step (skipped by a plain check),
//   recheck (skipped by add-tickets) and write-back; an absent source scans all TABLE_ENTRIES slots,
//   then creates a record or reports full or add-tickets; a sweep does a read-modify-write per valid slot
// throughput: one command at a time, the next accepted in the cycle after its result is loaded
// after reset the table is cleared one slot per cycle, all TABLE_ENTRIES slots, no input taken
`include "assert_macros.svh"

module per_source_flood_ban_table_core #(
    parameter int TABLE_ENTRIES = psfbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // source_addr, ticket_delta, now_seconds, sweep_count, zero pad
    input  logic [103:0]  s_axis_tdata,
    // cmd
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // allowed, record_found, record_created, banned_now, table_full, ban_total,
    // ticket_count, records_removed, zero pad
    output logic [63:0]   m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int RW = $bits(psfbt_pkg::t_rec);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_LK_RD  = 10'b00_0000_0100,
        S_LK_CHK = 10'b00_0000_1000,
        S_TICK   = 10'b00_0001_0000,
        S_RECHK  = 10'b00_0010_0000,
        S_WB     = 10'b00_0100_0000,
        S_SW_RD  = 10'b00_1000_0000,
        S_SW_CHK = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } t_state;

    t_state             r_state, n_state;
    psfbt_pkg::t_cfg    r_cfg;
    logic [1:0]         r_cmd, n_cmd;
    logic [47:0]        r_addr, n_addr;
    logic signed [10:0] r_delta, n_delta;
    logic [31:0]        r_now, n_now;
    logic [8:0]         r_count, n_count;
    logic [8:0]         r_left, n_left;
    logic [8:0]         r_removed, n_removed;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_free, n_free;
    logic               r_free_vld, n_free_vld;
    logic [AW-1:0]      r_slot, n_slot;
    logic [AW-1:0]      r_cursor, n_cursor;
    psfbt_pkg::t_rec    r_rec, n_rec;
    logic               r_created, n_created;
    logic               r_banned, n_banned;
    psfbt_pkg::t_result r_res, n_res;
    psfbt_pkg::t_result r_out, n_out;
    logic               r_ovld, n_ovld;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_rdata;
    psfbt_pkg::t_rec    q;

    psfbt_pkg::t_rec    alu_in, alu_out;
    psfbt_pkg::t_alu_op alu_op;
    logic signed [10:0] alu_delta;
    logic               alu_banned, alu_removed;

    logic               in_acc;
    logic               hit;
    logic               last;

    psfbt_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    psfbt_alu u_alu (
        .i_rec     (alu_in),
        .i_op      (alu_op),
        .i_delta   (alu_delta),
        .i_now     (r_now),
        .i_cfg     (r_cfg),
        .o_rec     (alu_out),
        .o_banned  (alu_banned),
        .o_removed (alu_removed)
    );

    assign q      = psfbt_pkg::t_rec'(ram_rdata);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign hit    = q.valid && (q.addr == r_addr);
    assign last   = r_idx == AW'(TABLE_ENTRIES - 1);

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {2'b00, r_out};
    assign pready        = 1'b1;

    always_comb begin
        case (paddr[3:2])
            psfbt_pkg::REG_WINDOW: prdata = {16'b0, r_cfg.window};
            psfbt_pkg::REG_MAX:    prdata = {16'b0, r_cfg.max_tickets};
            psfbt_pkg::REG_BAN:    prdata = {16'b0, r_cfg.ban};
            psfbt_pkg::REG_FORGET: prdata = {16'b0, r_cfg.forget};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window      <= psfbt_pkg::WINDOW_RST;
            r_cfg.max_tickets <= psfbt_pkg::MAX_RST;
            r_cfg.ban         <= psfbt_pkg::BAN_RST;
            r_cfg.forget      <= psfbt_pkg::FORGET_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                psfbt_pkg::REG_WINDOW: r_cfg.window      <= pwdata[15:0];
                psfbt_pkg::REG_MAX:    r_cfg.max_tickets <= pwdata[15:0];
                psfbt_pkg::REG_BAN:    r_cfg.ban         <= pwdata[15:0];
                psfbt_pkg::REG_FORGET: r_cfg.forget      <= pwdata[15:0];
                default:               r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        alu_in    = r_rec;
        alu_op    = psfbt_pkg::OP_RECHECK;
        alu_delta = r_delta;
        case (r_state)
            S_TICK: begin
                alu_op    = psfbt_pkg::OP_TICKET;
                alu_delta = (r_cmd == psfbt_pkg::CMD_ADD) ? r_delta : 11'sd1;
            end
            S_SW_CHK: begin
                alu_in = q;
                alu_op = psfbt_pkg::OP_SWEEP;
            end
            default: begin
                alu_op = psfbt_pkg::OP_RECHECK;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_idx;
        case (r_state)
            S_CLEAR: ram_we = 1'b1;
            S_SW_RD: ram_raddr = r_cursor;
            S_SW_CHK: begin
                ram_we    = q.valid;
                ram_waddr = r_cursor;
                ram_wdata = alu_out;
            end
            S_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_rec;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_delta    = r_delta;
        n_now      = r_now;
        n_count    = r_count;
        n_left     = r_left;
        n_removed  = r_removed;
        n_idx      = r_idx;
        n_free     = r_free;
        n_free_vld = r_free_vld;
        n_slot     = r_slot;
        n_cursor   = r_cursor;
        n_rec      = r_rec;
        n_created  = r_created;
        n_banned   = r_banned;
        n_res      = r_res;
        n_out      = r_out;
        n_ovld     = r_ovld && !m_axis_tready;
        case (r_state)
            S_CLEAR: begin
                n_idx = r_idx + AW'(1);
                if (last) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd      = s_axis_tuser;
                    n_addr     = s_axis_tdata[47:0];
                    n_delta    = s_axis_tdata[58:48];
                    n_now      = s_axis_tdata[90:59];
                    n_idx      = '0;
                    n_free_vld = 1'b0;
                    n_created  = 1'b0;
                    n_banned   = 1'b0;
                    n_removed  = '0;
                    n_res      = '0;
                    if (32'(s_axis_tdata[99:91]) > 32'(TABLE_ENTRIES)) begin
                        n_count = 9'(TABLE_ENTRIES);
                    end else begin
                        n_count = s_axis_tdata[99:91];
                    end
                    n_left  = n_count;
                    n_state = (s_axis_tuser == psfbt_pkg::CMD_SWEEP) ? S_SW_RD : S_LK_RD;
                end
            end
            S_LK_RD: n_state = S_LK_CHK;
            S_LK_CHK: begin
                if (hit) begin
                    n_slot  = r_idx;
                    n_rec   = q;
                    n_state = S_TICK;
                end else begin
                    if (!q.valid && !r_free_vld) begin
                        n_free     = r_idx;
                        n_free_vld = 1'b1;
                    end
                    if (!last) begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_LK_RD;
                    end else if (r_cmd == psfbt_pkg::CMD_ADD) begin
                        n_res.allowed = 1'b1;
                        n_state       = S_EMIT;
                    end else if (r_free_vld || !q.valid) begin
                        n_slot           = r_free_vld ? r_free : r_idx;
                        n_rec.valid        = 1'b1;
                        n_rec.addr         = r_addr;
                        n_rec.last_seen    = r_now;
                        n_rec.window_start = r_now;
                        n_rec.ban_until    = '0;
                        n_rec.tickets      = '0;
                        n_rec.bans         = '0;
                        n_created        = 1'b1;
                        n_state          = S_TICK;
                    end else begin
                        n_res.allowed = 1'b1;
                        n_res.full    = 1'b1;
                        n_state       = S_EMIT;
                    end
                end
            end
            S_TICK: begin
                if (r_cmd != psfbt_pkg::CMD_CHECK) begin
                    n_rec    = alu_out;
                    n_banned = alu_banned;
                end
                n_state = (r_cmd == psfbt_pkg::CMD_ADD) ? S_WB : S_RECHK;
            end
            S_RECHK: begin
                n_rec   = alu_out;
                n_state = S_WB;
            end
            S_WB: begin
                n_res.allowed = r_rec.ban_until == 32'd0;
                n_res.found   = 1'b1;
                n_res.created = r_created;
                n_res.banned  = r_banned;
                n_res.bans    = r_rec.bans;
                n_res.tickets = r_rec.tickets;
                n_state       = S_EMIT;
            end
            S_SW_RD: begin
                if (r_left == 9'd0) begin
                    n_res.removed = r_removed;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_SW_CHK;
                end
            end
            S_SW_CHK: begin
                n_removed = r_removed + 9'(alu_removed);
                n_left    = r_left - 9'd1;
                n_cursor  = (r_cursor == AW'(TABLE_ENTRIES - 1)) ? '0 : r_cursor + AW'(1);
                n_state   = S_SW_RD;
            end
            S_EMIT: begin
                if (!r_ovld || m_axis_tready) begin
                    n_out   = r_res;
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_cursor  <= '0;
            r_ovld    <= 1'b0;
            r_count   <= '0;
            r_removed <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cursor  <= n_cursor;
            r_ovld    <= n_ovld;
            r_count   <= n_count;
            r_removed <= n_removed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_delta    <= n_delta;
        r_now      <= n_now;
        r_left     <= n_left;
        r_free     <= n_free;
        r_free_vld <= n_free_vld;
        r_slot     <= n_slot;
        r_rec      <= n_rec;
        r_created  <= n_created;
        r_banned   <= n_banned;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    `PSF_ASSERT_IMPL(a_we_state, ram_we, r_state == S_CLEAR || r_state == S_SW_CHK || r_state == S_WB)
    `PSF_ASSERT_IMPL(a_rm_bound, r_state != S_CLEAR, r_removed <= r_count)
    `PSF_ASSERT_NEXT(a_add_wb, r_state == S_TICK && r_cmd == psfbt_pkg::CMD_ADD, r_state == S_WB)

endmodule
